>>> rtl/core/stil_pkg.sv
// Shared types, codes and defaults for the symbol table insert/lookup block.
package stil_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int NAME_BITS_DEF  = 64;
  localparam int TYPE_BITS_DEF  = 32;
  localparam int SCOPE_BITS_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_READ   = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_DUP   = 3'd2,
    ST_MISS  = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    RES_FULL,
    RES_DUP,
    RES_MISS,
    RES_RANGE,
    RES_INS,
    RES_HIT,
    RES_READ
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     scan_start;
    logic     scan_step;
    logic     read_issue;
    logic     ins_write;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  in_range;
    logic  scan_done;
    logic  hit;
    logic  out_free;
  } stat_t;

endpackage

>>> rtl/core/stil_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/stil_dp.sv
// Datapath: item capture, entry count, scan pointer, compare, result and output registers.
module stil_dp #(
  parameter int DEPTH      = stil_pkg::DEPTH_DEF,
  parameter int NAME_BITS  = stil_pkg::NAME_BITS_DEF,
  parameter int TYPE_BITS  = stil_pkg::TYPE_BITS_DEF,
  parameter int SCOPE_BITS = stil_pkg::SCOPE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  stil_pkg::cmd_t       cmd,
  output stil_pkg::stat_t      stat,
  input  logic [1:0]           kind,
  input  logic [63:0]          name_key,
  input  logic [31:0]          type_code,
  input  logic [31:0]          scope_key,
  input  logic [7:0]           read_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic [7:0]           entry_index,
  output logic [63:0]          found_name,
  output logic [31:0]          found_type,
  output logic [31:0]          found_scope,
  output logic [8:0]           count_now
);

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = NAME_BITS + TYPE_BITS + SCOPE_BITS;

  // Captured item
  stil_pkg::kind_t       kind_q;
  logic [NAME_BITS-1:0]  name_q;
  logic [TYPE_BITS-1:0]  type_q;
  logic [SCOPE_BITS-1:0] scope_q;
  logic [7:0]            ridx_q;

  logic [CNT_W-1:0]      count_q;

  // Scan state
  logic [CNT_W-1:0]      ptr_q;
  logic                  pend_q;
  logic [IDX_W-1:0]      pend_idx_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [NAME_BITS-1:0]  hit_name_q;
  logic [TYPE_BITS-1:0]  hit_type_q;
  logic [SCOPE_BITS-1:0] hit_scope_q;

  // Result stage
  stil_pkg::status_t     res_status;
  logic [IDX_W-1:0]      res_idx;
  logic [NAME_BITS-1:0]  res_name;
  logic [TYPE_BITS-1:0]  res_type;
  logic [SCOPE_BITS-1:0] res_scope;
  logic [CNT_W-1:0]      res_count;

  // RAM
  logic                  ram_wr_en;
  logic [IDX_W-1:0]      ram_wr_addr;
  logic [ENTRY_W-1:0]    ram_wr_data;
  logic                  ram_rd_en;
  logic [IDX_W-1:0]      ram_rd_addr;
  logic [ENTRY_W-1:0]    ram_rd_data;
  logic [NAME_BITS-1:0]  rd_name;
  logic [TYPE_BITS-1:0]  rd_type;
  logic [SCOPE_BITS-1:0] rd_scope;

  logic                  ptr_end;
  logic                  cmp_match;
  logic                  issue;
  logic                  out_free;

  assign rd_name  = ram_rd_data[ENTRY_W-1 -: NAME_BITS];
  assign rd_type  = ram_rd_data[SCOPE_BITS +: TYPE_BITS];
  assign rd_scope = ram_rd_data[SCOPE_BITS-1:0];

  assign ptr_end   = (ptr_q >= count_q);
  assign cmp_match = pend_q && !hit_q && (rd_name == name_q) && (rd_scope == scope_q);
  // Stop issuing once a match shows up; any read still in flight is ignored.
  assign issue     = cmd.scan_step && !ptr_end && !hit_q && !cmp_match;
  assign out_free  = !out_valid || !out_stall;

  assign ram_wr_en   = cmd.ins_write;
  assign ram_wr_addr = IDX_W'(count_q);
  assign ram_wr_data = {name_q, type_q, scope_q};
  assign ram_rd_en   = issue || cmd.read_issue;
  assign ram_rd_addr = cmd.read_issue ? IDX_W'(ridx_q) : IDX_W'(ptr_q);

  stil_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    stat.kind      = kind_q;
    stat.full      = (count_q == CNT_W'(DEPTH));
    stat.in_range  = (32'(ridx_q) < 32'(count_q));
    stat.scan_done = !pend_q && (hit_q || ptr_end);
    stat.hit       = hit_q;
    stat.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= stil_pkg::kind_t'(kind);
      name_q  <= NAME_BITS'(name_key);
      type_q  <= TYPE_BITS'(type_code);
      scope_q <= SCOPE_BITS'(scope_key);
      ridx_q  <= read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q <= '0;
    end else if (cmd.ins_write) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_q  <= '0;
      pend_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (cmd.scan_start) begin
      ptr_q  <= '0;
      pend_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (cmd.scan_step) begin
      pend_q <= issue;
      if (issue) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
      if (cmp_match) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx_q <= IDX_W'(ptr_q);
    end
    if (cmd.scan_step && cmp_match) begin
      hit_idx_q   <= pend_idx_q;
      hit_name_q  <= rd_name;
      hit_type_q  <= rd_type;
      hit_scope_q <= rd_scope;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_count <= count_q;
      res_idx   <= '0;
      res_name  <= '0;
      res_type  <= '0;
      res_scope <= '0;
      unique case (cmd.res_sel)
        stil_pkg::RES_FULL:  res_status <= stil_pkg::ST_FULL;
        stil_pkg::RES_DUP:   res_status <= stil_pkg::ST_DUP;
        stil_pkg::RES_MISS:  res_status <= stil_pkg::ST_MISS;
        stil_pkg::RES_RANGE: res_status <= stil_pkg::ST_RANGE;
        stil_pkg::RES_INS: begin
          res_status <= stil_pkg::ST_OK;
          res_idx    <= IDX_W'(count_q);
          res_name   <= name_q;
          res_type   <= type_q;
          res_scope  <= scope_q;
          res_count  <= count_q + CNT_W'(1);
        end
        stil_pkg::RES_HIT: begin
          res_status <= stil_pkg::ST_OK;
          res_idx    <= hit_idx_q;
          res_name   <= hit_name_q;
          res_type   <= hit_type_q;
          res_scope  <= hit_scope_q;
        end
        stil_pkg::RES_READ: begin
          res_status <= stil_pkg::ST_OK;
          res_idx    <= IDX_W'(ridx_q);
          res_name   <= rd_name;
          res_type   <= rd_type;
          res_scope  <= rd_scope;
        end
        default: res_status <= stil_pkg::ST_MISS;
      endcase
    end
  end

  // Output register: hold while stalled, reload once the previous transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= res_status;
      entry_index <= 8'(res_idx);
      found_name  <= 64'(res_name);
      found_type  <= 32'(res_type);
      found_scope <= 32'(res_scope);
      count_now   <= 9'(res_count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count_q) <= DEPTH)
    else $error("entry count above table depth");

  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> !stat.full)
    else $error("append into a full table");

  a_hit_below_count: assert property (@(posedge clk) disable iff (rst)
    hit_q |-> (32'(hit_idx_q) < 32'(count_q)))
    else $error("match index outside stored entries");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("output register overwritten before its transfer");

endmodule

>>> rtl/core/stil_ctrl.sv
// Controller: sequences capture, scan, read, append and result delivery.
module stil_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  stil_pkg::stat_t stat,
  output stil_pkg::cmd_t  cmd
);

  stil_pkg::state_t state;
  stil_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stil_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != stil_pkg::S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.res_sel = stil_pkg::RES_MISS;
    unique case (state)
      stil_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = stil_pkg::S_DECODE;
        end
      end
      stil_pkg::S_DECODE: begin
        unique case (stat.kind)
          stil_pkg::KIND_INSERT: begin
            if (stat.full) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = stil_pkg::RES_FULL;
              state_next   = stil_pkg::S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = stil_pkg::S_SCAN;
            end
          end
          stil_pkg::KIND_SEARCH: begin
            cmd.scan_start = 1'b1;
            state_next     = stil_pkg::S_SCAN;
          end
          stil_pkg::KIND_READ: begin
            if (stat.in_range) begin
              cmd.read_issue = 1'b1;
              state_next     = stil_pkg::S_READ;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = stil_pkg::RES_RANGE;
              state_next   = stil_pkg::S_DONE;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = stil_pkg::RES_MISS;
            state_next   = stil_pkg::S_DONE;
          end
        endcase
      end
      stil_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          cmd.res_load = 1'b1;
          state_next   = stil_pkg::S_DONE;
          if (stat.kind == stil_pkg::KIND_INSERT) begin
            if (stat.hit) begin
              cmd.res_sel = stil_pkg::RES_DUP;
            end else begin
              cmd.res_sel   = stil_pkg::RES_INS;
              cmd.ins_write = 1'b1;
            end
          end else begin
            cmd.res_sel = stat.hit ? stil_pkg::RES_HIT : stil_pkg::RES_MISS;
          end
        end
      end
      stil_pkg::S_READ: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = stil_pkg::RES_READ;
        state_next   = stil_pkg::S_DONE;
      end
      stil_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = stil_pkg::S_IDLE;
        end
      end
      default: state_next = stil_pkg::S_IDLE;
    endcase
  end

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == stil_pkg::S_SCAN && stat.scan_done) |=> (state == stil_pkg::S_DONE))
    else $error("scan finished but result not taken");

endmodule

>>> rtl/core/symbol_table_insert_lookup.sv
// An input item passes S_DECODE, then S_SCAN (search, insert), S_READ (read) or neither
// (full, out-of-range and reserved kinds), and S_DONE loads the output register. A scan makes
// one RAM read per entry, compared in the following cycle, and stops at a match.
// One item is in work at a time; the next input transfer can land the cycle after the result
// is loaded into the output register.
// Reset clears the entry count, controller state and out_valid; entry storage is not cleared.
module symbol_table_insert_lookup #(
  parameter int DEPTH      = stil_pkg::DEPTH_DEF,
  parameter int NAME_BITS  = stil_pkg::NAME_BITS_DEF,
  parameter int TYPE_BITS  = stil_pkg::TYPE_BITS_DEF,
  parameter int SCOPE_BITS = stil_pkg::SCOPE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [63:0] name_key,
  input  logic [31:0] type_code,
  input  logic [31:0] scope_key,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  entry_index,
  output logic [63:0] found_name,
  output logic [31:0] found_type,
  output logic [31:0] found_scope,
  output logic [8:0]  count_now
);

  stil_pkg::cmd_t  cmd;
  stil_pkg::stat_t stat;

  stil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  stil_dp #(
    .DEPTH      (DEPTH),
    .NAME_BITS  (NAME_BITS),
    .TYPE_BITS  (TYPE_BITS),
    .SCOPE_BITS (SCOPE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (kind),
    .name_key    (name_key),
    .type_code   (type_code),
    .scope_key   (scope_key),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_index (entry_index),
    .found_name  (found_name),
    .found_type  (found_type),
    .found_scope (found_scope),
    .count_now   (count_now)
  );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the symbol table insert/search/read block.
`timescale 1ns / 1ps

module tb_top;

  localparam int TBL_DEPTH = stil_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    stil_pkg::kind_t kind;
    logic [63:0]     name_key;
    logic [31:0]     type_code;
    logic [31:0]     scope_key;
    logic [7:0]      read_index;
  } sym_req_t;

  typedef struct packed {
    stil_pkg::status_t status;
    logic [7:0]        entry_index;
    logic [63:0]       found_name;
    logic [31:0]       found_type;
    logic [31:0]       found_scope;
    logic [8:0]        count_now;
  } sym_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = 2'd0;
  logic [63:0] name_key = '0;
  logic [31:0] type_code = '0;
  logic [31:0] scope_key = '0;
  logic [7:0]  read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [7:0]  entry_index;
  logic [63:0] found_name;
  logic [31:0] found_type;
  logic [31:0] found_scope;
  logic [8:0]  count_now;

  sym_req_t pending_reqs[$];
  sym_res_t expected_res[$];
  sym_req_t cur_req;
  sym_res_t want;
  logic     in_done = 1'b0;

  // Shadow of the table contents
  logic [63:0] tbl_name[TBL_DEPTH];
  logic [31:0] tbl_type[TBL_DEPTH];
  logic [31:0] tbl_scope[TBL_DEPTH];
  int          tbl_count = 0;

  // Stimulus-side bookkeeping: keys sent for insert, fresh inserts issued
  logic [63:0] pool_name[$];
  logic [31:0] pool_scope[$];
  int          gen_count = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errs = 0;
  int cycles = 0;

  symbol_table_insert_lookup dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .name_key   (name_key),
    .type_code  (type_code),
    .scope_key  (scope_key),
    .read_index (read_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .entry_index(entry_index),
    .found_name (found_name),
    .found_type (found_type),
    .found_scope(found_scope),
    .count_now  (count_now)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // First entry matching both keys, or -1
  function automatic int scan_table(logic [63:0] nm, logic [31:0] sc);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_name[i] == nm && tbl_scope[i] == sc) return i;
    end
    return -1;
  endfunction

  function automatic sym_res_t predict_lookup(sym_req_t req);
    sym_res_t res;
    int       pos;
    res = '0;
    pos = -1;
    res.status = stil_pkg::ST_MISS;
    case (req.kind)
      stil_pkg::KIND_INSERT: begin
        if (tbl_count >= TBL_DEPTH) begin
          res.status = stil_pkg::ST_FULL;
        end else if (scan_table(req.name_key, req.scope_key) >= 0) begin
          res.status = stil_pkg::ST_DUP;
        end else begin
          pos = tbl_count;
          tbl_name[pos]  = req.name_key;
          tbl_type[pos]  = req.type_code;
          tbl_scope[pos] = req.scope_key;
          tbl_count++;
        end
      end
      stil_pkg::KIND_SEARCH: begin
        pos = scan_table(req.name_key, req.scope_key);
      end
      stil_pkg::KIND_READ: begin
        if (int'(req.read_index) < tbl_count) pos = int'(req.read_index);
        else res.status = stil_pkg::ST_RANGE;
      end
      default: ;
    endcase
    if (pos >= 0) begin
      res.status      = stil_pkg::ST_OK;
      res.entry_index = pos[7:0];
      res.found_name  = tbl_name[pos];
      res.found_type  = tbl_type[pos];
      res.found_scope = tbl_scope[pos];
    end
    res.count_now = tbl_count[8:0];
    return res;
  endfunction

  task automatic push_item(stil_pkg::kind_t kd, logic [63:0] nm, logic [31:0] ty,
                           logic [31:0] sc, logic [7:0] ri);
    sym_req_t req;
    req.kind       = kd;
    req.name_key   = nm;
    req.type_code  = ty;
    req.scope_key  = sc;
    req.read_index = ri;
    pending_reqs.push_back(req);
  endtask

  // Mostly well-formed traffic: fresh keys, repeats, hits, near misses, reads
  task automatic gen_random(int n);
    int              r;
    int              pick;
    int              lim;
    stil_pkg::kind_t kd;
    logic [63:0]     nm;
    logic [31:0]     ty;
    logic [31:0]     sc;
    logic [7:0]      ri;
    for (int j = 0; j < n; j++) begin
      r  = $urandom_range(99);
      nm = {$urandom(), $urandom()};
      ty = $urandom();
      sc = $urandom();
      ri = 8'($urandom_range(255));
      pick = (pool_name.size() != 0) ? $urandom_range(pool_name.size() - 1) : 0;
      if (r < 30 || (r < 75 && pool_name.size() == 0)) begin
        kd = stil_pkg::KIND_INSERT;
        case ($urandom_range(3))
          0: if (pool_name.size() != 0) nm = pool_name[pick];
          1: if (pool_name.size() != 0) sc = pool_scope[pick];
          default: ;
        endcase
        pool_name.push_back(nm);
        pool_scope.push_back(sc);
        gen_count++;
      end else if (r < 40) begin
        kd = stil_pkg::KIND_INSERT;
        nm = pool_name[pick];
        sc = pool_scope[pick];
      end else if (r < 65) begin
        kd = stil_pkg::KIND_SEARCH;
        nm = pool_name[pick];
        sc = pool_scope[pick];
      end else if (r < 75) begin
        kd = stil_pkg::KIND_SEARCH;
        nm = pool_name[pick];
        sc = pool_scope[pick];
        if ($urandom_range(1)) sc = sc ^ (32'd1 << $urandom_range(31));
        else nm = nm ^ (64'd1 << $urandom_range(63));
      end else if (r < 96) begin
        kd = stil_pkg::KIND_READ;
        lim = (gen_count > TBL_DEPTH) ? TBL_DEPTH : gen_count;
        if (lim > 0 && $urandom_range(3) != 0) ri = 8'($urandom_range(lim - 1));
      end else begin
        kd = stil_pkg::KIND_RSVD;
      end
      push_item(kd, nm, ty, sc, ri);
    end
  endtask

  task automatic check_field(string fname, logic [63:0] exp_val, logic [63:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected 'h%0h, got 'h%0h", fname, exp_val, got_val);
      errs++;
    end
  endtask

  // Input side: predict each accepted transfer
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_res.push_back(predict_lookup(cur_req));
      in_done = 1'b1;
    end
  end

  // Driver: hold the payload until the transfer completes
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_done) begin
      in_done = 1'b0;
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        in_valid   <= 1'b1;
        kind       <= cur_req.kind;
        name_key   <= cur_req.name_key;
        type_code  <= cur_req.type_code;
        scope_key  <= cur_req.scope_key;
        read_index <= cur_req.read_index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_res.size() == 0) begin
        $error("result with nothing pending: status %0d index %0d", status, entry_index);
        errs++;
      end else begin
        want = expected_res.pop_front();
        check_field("status", 64'(want.status), 64'(status));
        check_field("entry_index", 64'(want.entry_index), 64'(entry_index));
        check_field("found_name", want.found_name, found_name);
        check_field("found_type", 64'(want.found_type), 64'(found_type));
        check_field("found_scope", 64'(want.found_scope), 64'(found_scope));
        check_field("count_now", 64'(want.count_now), 64'(count_now));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 17;
    recv_idle_pct = 66;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table, reserved kind, zero and all-ones keys, partial key matches
    push_item(stil_pkg::KIND_SEARCH, '0, '0, '0, 8'd0);
    push_item(stil_pkg::KIND_READ, '0, '0, '0, 8'd0);
    push_item(stil_pkg::KIND_READ, '1, '1, '1, 8'd255);
    push_item(stil_pkg::KIND_RSVD, '0, '0, '0, 8'd0);
    push_item(stil_pkg::KIND_INSERT, '0, '0, '0, 8'd0);
    push_item(stil_pkg::KIND_INSERT, '1, '1, '1, 8'd255);
    push_item(stil_pkg::KIND_INSERT, '0, '1, '0, 8'd0);
    push_item(stil_pkg::KIND_INSERT, '1, 32'h0000_00a5, '0, 8'd0);
    push_item(stil_pkg::KIND_INSERT, '0, 32'h5a00_0000, '1, 8'd0);
    push_item(stil_pkg::KIND_SEARCH, '1, '0, '1, 8'd0);
    push_item(stil_pkg::KIND_SEARCH, '1, '0, '0, 8'd0);
    push_item(stil_pkg::KIND_SEARCH, 64'd1, '0, '0, 8'd0);
    push_item(stil_pkg::KIND_SEARCH, '0, '0, 32'h8000_0000, 8'd0);
    push_item(stil_pkg::KIND_READ, '0, '0, '0, 8'd0);
    push_item(stil_pkg::KIND_READ, '0, '0, '0, 8'd3);
    push_item(stil_pkg::KIND_READ, '0, '0, '0, 8'd4);
    push_item(stil_pkg::KIND_READ, '0, '0, '0, 8'd255);
    push_item(stil_pkg::KIND_INSERT, 64'h0123_4567_89ab_cdef, 32'h5a5a_a5a5, 32'h89ab_cdef,
              8'd0);
    push_item(stil_pkg::KIND_RSVD, '1, '1, '1, 8'd255);
    push_item(stil_pkg::KIND_READ, '0, '0, '0, 8'd4);
    push_item(stil_pkg::KIND_SEARCH, 64'h0123_4567_89ab_cdef, '0, 32'h89ab_cdef, 8'd0);
    push_item(stil_pkg::KIND_SEARCH, '1, '0, '1, 8'd0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 17 : 0;
      gen_random(500);
      while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    end

    while (expected_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errs == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/stil_pkg.sv
rtl/core/stil_ram.sv
rtl/core/stil_dp.sv
rtl/core/stil_ctrl.sv
rtl/core/symbol_table_insert_lookup.sv
sim/tb_top.sv
